// File: rtl/ehp_pkg.sv
// eCPRI header parser package: widths, status codes, register indexes,
// configuration and result record types. No dependencies.
`timescale 1ns / 1ps

package ehp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned HALF_W      = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned FIFO_DEPTH  = 4;

  localparam logic [HALF_W-1:0] HDR_BYTES   = 16'd4;
  localparam logic [HALF_W-1:0] FIELD_BYTES = 16'd4;
  localparam logic [HALF_W-1:0] PAYLOAD_POS = 16'd8;
  localparam logic [HALF_W-1:0] MAX16       = 16'hFFFF;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT_HDR   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_REV     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CONCAT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SIZE_EXCEED = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NO_FIELDS   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_EXP_REV  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IQ_TYPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RTC_TYPE = 3'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [3:0]        expected_revision;
    logic              use_header_size;
    logic [BYTE_W-1:0] iq_type_code;
    logic [BYTE_W-1:0] rtc_type_code;
  } ehp_cfg_t;

  typedef struct packed {
    logic                kind;
    logic                run_end;
    logic [STATUS_W-1:0] status;
    logic [HALF_W-1:0]   forwarded_length;
    logic [HALF_W-1:0]   header_payload_size;
    logic [HALF_W-1:0]   sequence_id;
    logic [HALF_W-1:0]   stream_id;
    logic [BYTE_W-1:0]   message_kind;
    logic [BYTE_W-1:0]   payload_byte;
  } ehp_rec_t;

endpackage

// File: rtl/ehp_parse.sv
// Per-packet header capture, forwarding decision and summary status.
// Depends on ehp_pkg.
`timescale 1ns / 1ps

module ehp_parse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ehp_pkg::ehp_cfg_t         cfg,
  input  logic                      in_fire,
  input  logic [ehp_pkg::BYTE_W-1:0] in_byte,
  input  logic                      in_last,
  output ehp_pkg::ehp_rec_t         pay_rec,
  output logic                      pay_vld,
  output ehp_pkg::ehp_rec_t         sum_rec,
  output logic                      sum_vld
);

  logic [ehp_pkg::HALF_W-1:0] pos_r, pos_nxt;
  logic [ehp_pkg::BYTE_W-1:0] fhb_r, fhb_nxt;
  logic [ehp_pkg::BYTE_W-1:0] type_r, type_nxt;
  logic [ehp_pkg::HALF_W-1:0] size_r, size_nxt;
  logic [ehp_pkg::HALF_W-1:0] id_r, id_nxt;
  logic [ehp_pkg::HALF_W-1:0] seq_r, seq_nxt;
  logic [ehp_pkg::HALF_W-1:0] fwd_r, fwd_nxt;

  logic [ehp_pkg::BYTE_W-1:0]   fhb_c, type_c;
  logic [ehp_pkg::HALF_W-1:0]   size_c, id_c, seq_c, fwd_c, n_c, rest_c;
  logic                         rev_ok, type_ok, fwd_en;
  logic [ehp_pkg::STATUS_W-1:0] status_c;

  // capture header bytes by position
  always_comb begin
    fhb_c  = fhb_r;
    type_c = type_r;
    size_c = size_r;
    id_c   = id_r;
    seq_c  = seq_r;
    unique case (pos_r)
      16'd0:   fhb_c = in_byte;
      16'd1:   type_c = in_byte;
      16'd2:   size_c = {in_byte, size_r[7:0]};
      16'd3:   size_c = {size_r[15:8], in_byte};
      16'd4:   id_c = {in_byte, id_r[7:0]};
      16'd5:   id_c = {id_r[15:8], in_byte};
      16'd6:   seq_c = {in_byte, seq_r[7:0]};
      16'd7:   seq_c = {seq_r[15:8], in_byte};
      default: ;
    endcase
  end

  assign rev_ok  = (fhb_c[7:4] == cfg.expected_revision);
  assign type_ok = (type_c == cfg.iq_type_code) || (type_c == cfg.rtc_type_code);

  // forwarding decision
  always_comb begin
    fwd_en = (pos_r >= ehp_pkg::PAYLOAD_POS) && (pos_r != ehp_pkg::MAX16) &&
             rev_ok && !fhb_c[0] && type_ok;
    if (cfg.use_header_size) begin
      fwd_en = fwd_en && (size_c >= ehp_pkg::FIELD_BYTES) &&
               ((pos_r - ehp_pkg::PAYLOAD_POS) < (size_c - ehp_pkg::FIELD_BYTES));
    end
  end

  assign fwd_c  = (fwd_en && (fwd_r != ehp_pkg::MAX16)) ? fwd_r + 16'd1 : fwd_r;
  assign n_c    = (pos_r != ehp_pkg::MAX16) ? pos_r + 16'd1 : ehp_pkg::MAX16;
  assign rest_c = n_c - ehp_pkg::HDR_BYTES;

  always_comb begin
    priority if (n_c < ehp_pkg::HDR_BYTES) begin
      status_c = ehp_pkg::ST_SHORT_HDR;
    end else if (!rev_ok) begin
      status_c = ehp_pkg::ST_BAD_REV;
    end else if (fhb_c[0]) begin
      status_c = ehp_pkg::ST_CONCAT;
    end else if (n_c == ehp_pkg::HDR_BYTES) begin
      status_c = ehp_pkg::ST_NO_FIELDS;
    end else if (cfg.use_header_size && (size_c > rest_c)) begin
      status_c = ehp_pkg::ST_SIZE_EXCEED;
    end else if (!type_ok) begin
      status_c = ehp_pkg::ST_BAD_TYPE;
    end else if (rest_c < ehp_pkg::FIELD_BYTES) begin
      status_c = ehp_pkg::ST_NO_FIELDS;
    end else if (cfg.use_header_size && (size_c < ehp_pkg::FIELD_BYTES)) begin
      status_c = ehp_pkg::ST_NO_FIELDS;
    end else begin
      status_c = ehp_pkg::ST_OK;
    end
  end

  always_comb begin
    pay_rec              = '0;
    pay_rec.kind         = ehp_pkg::KIND_PAYLOAD;
    pay_rec.payload_byte = in_byte;
    pay_vld              = in_fire && fwd_en;

    sum_rec                     = '0;
    sum_rec.kind                = ehp_pkg::KIND_SUMMARY;
    sum_rec.run_end             = 1'b1;
    sum_rec.status              = status_c;
    sum_rec.forwarded_length    = fwd_c;
    sum_rec.header_payload_size = size_c;
    sum_rec.sequence_id         = seq_c;
    sum_rec.stream_id           = id_c;
    sum_rec.message_kind        = type_c;
    sum_vld                     = in_fire && in_last;
  end

  always_comb begin
    pos_nxt  = pos_r;
    fhb_nxt  = fhb_r;
    type_nxt = type_r;
    size_nxt = size_r;
    id_nxt   = id_r;
    seq_nxt  = seq_r;
    fwd_nxt  = fwd_r;
    if (in_fire) begin
      if (in_last) begin
        pos_nxt  = '0;
        fhb_nxt  = '0;
        type_nxt = '0;
        size_nxt = '0;
        id_nxt   = '0;
        seq_nxt  = '0;
        fwd_nxt  = '0;
      end else begin
        pos_nxt  = n_c;
        fhb_nxt  = fhb_c;
        type_nxt = type_c;
        size_nxt = size_c;
        id_nxt   = id_c;
        seq_nxt  = seq_c;
        fwd_nxt  = fwd_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fhb_r  <= '0;
      type_r <= '0;
      size_r <= '0;
      id_r   <= '0;
      seq_r  <= '0;
      fwd_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      fhb_r  <= fhb_nxt;
      type_r <= type_nxt;
      size_r <= size_nxt;
      id_r   <= id_nxt;
      seq_r  <= seq_nxt;
      fwd_r  <= fwd_nxt;
    end
  end

endmodule

// File: rtl/ehp_fifo.sv
// Result queue taking up to two records per cycle and giving one per cycle while rd_rdy is high.
// Depends on ehp_pkg.
`timescale 1ns / 1ps

module ehp_fifo #(
  parameter int unsigned DEPTH = ehp_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ehp_pkg::ehp_rec_t wr_a,
  input  logic              wr_a_vld,
  input  ehp_pkg::ehp_rec_t wr_b,
  input  logic              wr_b_vld,
  output logic              room2,
  output ehp_pkg::ehp_rec_t rd_rec,
  output logic              rd_vld,
  input  logic              rd_rdy
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] ROOM_LIM = CNT_W'(DEPTH - 2);

  ehp_pkg::ehp_rec_t mem_r [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [1:0]       n_push;
  ehp_pkg::ehp_rec_t first_rec;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign rd_vld    = (cnt_r != '0);
  assign rd_rec    = mem_r[rd_ptr_r];
  assign room2     = (cnt_r <= ROOM_LIM);
  assign pop       = rd_vld && rd_rdy;
  assign n_push    = {1'b0, wr_a_vld} + {1'b0, wr_b_vld};
  assign first_rec = wr_a_vld ? wr_a : wr_b;
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (n_push == 2'd1) begin
      wr_ptr_nxt = wr_ptr_p1;
    end else if (n_push == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= first_rec;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_p1] <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/ecpri_header_parser_core.sv
// eCPRI common header parser top level: configuration registers, parser
// and result queue. Depends on ehp_pkg, ehp_parse and ehp_fifo.
`timescale 1ns / 1ps

// Usage
// in_*: one packet byte per word, in_tlast on the last byte of a packet.
// out_*: one result word per handshake. out_tuser 0 is a forwarded payload
// byte, out_tuser 1 the end-of-packet summary, which also carries out_tlast.
// A byte makes at most two words: its payload word, then the summary.
// cfg_*: register writes, always ready, taken effect from the next byte.
// Result words are registered in the result queue and shown on out_* from its head.
// Throughput: one byte per cycle while the receiver takes one word per cycle;
// the last byte of a packet that also forwards a payload byte adds one word,
// absorbed by the FIFO_DEPTH result queue.
// in_tready is low while the queue holds more than FIFO_DEPTH-2 words.
// When out_tready is low, words wait in the queue and in_tready drops once
// it fills.
// Reset (synchronous, rst_n low): registers return to revision 1, size mode
// on, IQ type 0, RTC type 2; packet state and queue are cleared.
module ecpri_header_parser_core #(
  parameter int unsigned FIFO_DEPTH = ehp_pkg::FIFO_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ehp_pkg::BYTE_W-1:0]       in_tdata,  // data_byte
  input  logic                             in_tlast,  // end_of_input
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // payload_byte, message_kind, stream_id, sequence_id, header_payload_size,
  // forwarded_length, status, zero pad
  output logic [ehp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tuser, // kind
  output logic                             out_tlast, // run_end
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ehp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ehp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned PAD_W = ehp_pkg::OUT_TDATA_W - ehp_pkg::STATUS_W
                                  - 4 * ehp_pkg::HALF_W - 2 * ehp_pkg::BYTE_W;

  ehp_pkg::ehp_cfg_t cfg_r, cfg_nxt;
  ehp_pkg::ehp_rec_t pay_rec, sum_rec, head_rec;
  logic              pay_vld, sum_vld, room2, in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = room2;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        ehp_pkg::REG_EXP_REV:  cfg_nxt.expected_revision = cfg_data[3:0];
        ehp_pkg::REG_USE_SIZE: cfg_nxt.use_header_size = cfg_data[0];
        ehp_pkg::REG_IQ_TYPE:  cfg_nxt.iq_type_code = cfg_data;
        ehp_pkg::REG_RTC_TYPE: cfg_nxt.rtc_type_code = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_revision <= 4'd1;
      cfg_r.use_header_size   <= 1'b1;
      cfg_r.iq_type_code      <= 8'd0;
      cfg_r.rtc_type_code     <= 8'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ehp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .pay_rec (pay_rec),
    .pay_vld (pay_vld),
    .sum_rec (sum_rec),
    .sum_vld (sum_vld)
  );

  ehp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_a     (pay_rec),
    .wr_a_vld (pay_vld),
    .wr_b     (sum_rec),
    .wr_b_vld (sum_vld),
    .room2    (room2),
    .rd_rec   (head_rec),
    .rd_vld   (out_tvalid),
    .rd_rdy   (out_tready)
  );

  assign out_tdata = {{PAD_W{1'b0}},
                      head_rec.status,
                      head_rec.forwarded_length,
                      head_rec.header_payload_size,
                      head_rec.sequence_id,
                      head_rec.stream_id,
                      head_rec.message_kind,
                      head_rec.payload_byte};
  assign out_tuser = head_rec.kind;
  assign out_tlast = head_rec.run_end;

endmodule

// File: rtl/ehp_checker.sv
// Port-level checks for the eCPRI header parser, bound to the top level.
// Depends on ehp_pkg and ecpri_header_parser_core.
`timescale 1ns / 1ps

module ehp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ehp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word shown right after reset");

  a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == out_tlast))
    else $error("tlast does not match summary kind");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ehp_pkg::KIND_PAYLOAD)
      |-> (out_tdata[ehp_pkg::OUT_TDATA_W-1:ehp_pkg::BYTE_W] == '0))
    else $error("payload word carries summary fields");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[82:80] != 3'd7))
    else $error("undefined status code");

endmodule

bind ecpri_header_parser_core ehp_checker u_ehp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: tb/tb_top.sv
// Self-checking testbench for ecpri_header_parser_core: directed and random byte
// streams with random idling and register changes, checked word by word.
// Depends on ehp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_top;
  import ehp_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BYTES = 1400;
  localparam int RAND_PHASES  = 8;
  localparam int SETTLE       = 4;
  localparam int PRINT_CAP    = 30;
  localparam int IDLE_MAX     = 18;

  class ehp_record_checker;
    logic [3:0]  exp_rev;
    logic        size_mode;
    logic [7:0]  iq_code;
    logic [7:0]  rtc_code;
    logic [15:0] pos;
    logic [7:0]  hdr0;
    logic [7:0]  typ;
    logic [15:0] size;
    logic [15:0] id;
    logic [15:0] seq;
    logic [15:0] fwd_cnt;
    ehp_rec_t    expected_recs[$];
    int          errors;
    int          payload_words;
    int          summaries;
    int          status_seen[8];

    function new();
      exp_rev   = 4'd1;
      size_mode = 1'b1;
      iq_code   = 8'd0;
      rtc_code  = 8'd2;
      errors    = 0;
      payload_words = 0;
      summaries = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos     = '0;
      hdr0    = '0;
      typ     = '0;
      size    = '0;
      id      = '0;
      seq     = '0;
      fwd_cnt = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_EXP_REV:  exp_rev   = val[3:0];
        REG_USE_SIZE: size_mode = val[0];
        REG_IQ_TYPE:  iq_code   = val;
        REG_RTC_TYPE: rtc_code  = val;
        default: ;
      endcase
    endfunction

    function bit type_known();
      return typ == iq_code || typ == rtc_code;
    endfunction

    function logic [STATUS_W-1:0] frame_status(logic [15:0] n);
      logic [15:0] rest;
      if (n < HDR_BYTES) return ST_SHORT_HDR;
      if (hdr0[7:4] != exp_rev) return ST_BAD_REV;
      if (hdr0[0]) return ST_CONCAT;
      if (n == HDR_BYTES) return ST_NO_FIELDS;
      rest = n - HDR_BYTES;
      if (size_mode && size > rest) return ST_SIZE_EXCEED;
      if (!type_known()) return ST_BAD_TYPE;
      if (rest < FIELD_BYTES) return ST_NO_FIELDS;
      if (size_mode && size < FIELD_BYTES) return ST_NO_FIELDS;
      return ST_OK;
    endfunction

    // predicts the words that one accepted input byte produces
    function void take_byte(logic [7:0] b, logic last);
      ehp_rec_t    rec;
      logic [15:0] p;
      bit          fwd;
      p = pos;
      case (p)
        16'd0: hdr0 = b;
        16'd1: typ = b;
        16'd2: size[15:8] = b;
        16'd3: size[7:0] = b;
        16'd4: id[15:8] = b;
        16'd5: id[7:0] = b;
        16'd6: seq[15:8] = b;
        16'd7: seq[7:0] = b;
        default: ;
      endcase
      if (p >= PAYLOAD_POS && p != MAX16 && hdr0[7:4] == exp_rev && !hdr0[0] &&
          type_known()) begin
        fwd = !size_mode ||
              (size >= FIELD_BYTES && (p - PAYLOAD_POS) < (size - FIELD_BYTES));
        if (fwd) begin
          rec = '0;
          rec.kind = KIND_PAYLOAD;
          rec.payload_byte = b;
          expected_recs.push_back(rec);
          if (fwd_cnt != MAX16) fwd_cnt = fwd_cnt + 16'd1;
        end
      end
      pos = (p != MAX16) ? p + 16'd1 : MAX16;
      if (last) begin
        rec = '0;
        rec.kind                = KIND_SUMMARY;
        rec.message_kind        = typ;
        rec.stream_id           = id;
        rec.sequence_id         = seq;
        rec.header_payload_size = size;
        rec.forwarded_length    = fwd_cnt;
        rec.status              = frame_status(pos);
        rec.run_end             = 1'b1;
        expected_recs.push_back(rec);
        clear_frame();
      end
    endfunction

    function void report_field(string name, logic [15:0] e, logic [15:0] a);
      errors++;
      if (errors <= PRINT_CAP) $error("%s: expected %h, got %h", name, e, a);
    endfunction

    function void check_word(logic user, logic last, logic [OUT_TDATA_W-1:0] data);
      ehp_rec_t e;
      if (expected_recs.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP) $error("word with nothing expected: kind %b data %h", user, data);
        return;
      end
      e = expected_recs.pop_front();
      if (user !== e.kind) report_field("kind", 16'(e.kind), 16'(user));
      if (last !== e.run_end) report_field("run_end", 16'(e.run_end), 16'(last));
      if (data[7:0] !== e.payload_byte)
        report_field("payload_byte", 16'(e.payload_byte), 16'(data[7:0]));
      if (data[15:8] !== e.message_kind)
        report_field("message_kind", 16'(e.message_kind), 16'(data[15:8]));
      if (data[31:16] !== e.stream_id) report_field("stream_id", e.stream_id, data[31:16]);
      if (data[47:32] !== e.sequence_id) report_field("sequence_id", e.sequence_id, data[47:32]);
      if (data[63:48] !== e.header_payload_size)
        report_field("header_payload_size", e.header_payload_size, data[63:48]);
      if (data[79:64] !== e.forwarded_length)
        report_field("forwarded_length", e.forwarded_length, data[79:64]);
      if (data[82:80] !== e.status) report_field("status", 16'(e.status), 16'(data[82:80]));
      if (e.kind == KIND_PAYLOAD) begin
        payload_words++;
      end else begin
        summaries++;
        status_seen[e.status]++;
      end
    endfunction

    function int pending();
      return expected_recs.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  ehp_record_checker sb = new();

  logic [7:0] pkt_bytes[$];
  logic [3:0] cur_rev = 4'd1;
  logic [7:0] cur_iq = 8'd0;
  logic [7:0] cur_rtc = 8'd2;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  int         rx_hold = 0;
  int         bytes_sent = 0;
  int         frames_sent = 0;
  int         cycle_count = 0;

  ecpri_header_parser_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.take_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_word(out_tuser, out_tlast, out_tdata);
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= (rx_hold == 1);
    end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
      rx_hold <= $urandom_range(1, IDLE_MAX);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, sb.pending());
      $display("ecpri_header_parser_core: mismatch");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    frames_sent++;
  endtask

  task automatic build_frame(input logic [3:0] rev, input logic concat, input logic [7:0] typ,
                             input logic [15:0] size, input logic [15:0] id,
                             input logic [15:0] seq, input int pay_len);
    pkt_bytes.delete();
    pkt_bytes.push_back({rev, 3'($urandom), concat});
    pkt_bytes.push_back(typ);
    pkt_bytes.push_back(size[15:8]);
    pkt_bytes.push_back(size[7:0]);
    pkt_bytes.push_back(id[15:8]);
    pkt_bytes.push_back(id[7:0]);
    pkt_bytes.push_back(seq[15:8]);
    pkt_bytes.push_back(seq[7:0]);
    repeat (pay_len) pkt_bytes.push_back(8'($urandom));
  endtask

  task automatic cut_frame(input int len);
    while (pkt_bytes.size() > len) pkt_bytes.delete(pkt_bytes.size() - 1);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_cfg(input logic [3:0] rev, input logic mode, input logic [7:0] iq,
                           input logic [7:0] rtc);
    put_reg(REG_EXP_REV, {4'h0, rev});
    put_reg(REG_USE_SIZE, {7'h0, mode});
    put_reg(REG_IQ_TYPE, iq);
    put_reg(REG_RTC_TYPE, rtc);
    cfg_valid <= 1'b0;
    cur_rev  = rev;
    cur_iq   = iq;
    cur_rtc  = rtc;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly well-formed frames with random content, some truncated, some noise
  task automatic gen_frame();
    int         roll;
    int         pay_len;
    int         sz;
    logic [3:0] rev;
    logic [7:0] typ;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      pkt_bytes.delete();
      repeat ($urandom_range(1, 12)) pkt_bytes.push_back(8'($urandom));
    end else begin
      rev = ($urandom_range(0, 9) == 0) ? 4'($urandom) : cur_rev;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: typ = cur_iq;
        4, 5, 6, 7, 8: typ = cur_rtc;
        default: typ = 8'($urandom);
      endcase
      pay_len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
      case ($urandom_range(0, 9))
        0: sz = $urandom_range(0, 7);
        1, 2: sz = pay_len + 4 + $urandom_range(0, 6) - 3;
        default: sz = pay_len + 4;
      endcase
      if (sz < 0) sz = 0;
      build_frame(rev, $urandom_range(0, 9) == 0, typ, 16'(sz), 16'($urandom), 16'($urandom),
                  pay_len);
      if (roll < 30) cut_frame($urandom_range(1, pkt_bytes.size()));
    end
    send_frame();
  endtask

  initial begin
    int phase_start;
    int pick;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, every status
    build_frame(4'd1, 1'b0, 8'd0, 16'd8, 16'h1234, 16'h5678, 4); cut_frame(1); send_frame();
    build_frame(4'd1, 1'b0, 8'd0, 16'd8, 16'h1234, 16'h5678, 4); cut_frame(3); send_frame();
    build_frame(4'd2, 1'b0, 8'd0, 16'd8, 16'h0, 16'h0, 0); cut_frame(4); send_frame();
    build_frame(4'd1, 1'b1, 8'd0, 16'd8, 16'h0, 16'h0, 0); cut_frame(4); send_frame();
    build_frame(4'd1, 1'b0, 8'd0, 16'd8, 16'h0, 16'h0, 0); cut_frame(4); send_frame();
    build_frame(4'd1, 1'b0, 8'd0, 16'd10, 16'hA5A5, 16'h5A5A, 0); send_frame();
    build_frame(4'd1, 1'b0, 8'd5, 16'd8, 16'h0001, 16'h0002, 4); send_frame();
    build_frame(4'd1, 1'b0, 8'd2, 16'd2, 16'hFFFF, 16'h0, 0); cut_frame(6); send_frame();
    build_frame(4'd1, 1'b0, 8'd0, 16'd3, 16'h00FF, 16'hFF00, 1); send_frame();
    build_frame(4'd1, 1'b0, 8'd0, 16'd8, 16'h8001, 16'h7FFE, 6); send_frame();
    build_frame(4'd1, 1'b0, 8'd2, 16'd4, 16'h0000, 16'hFFFF, 0); send_frame();
    drain();

    // extremes, equal type codes, size mode off
    write_cfg(4'd15, 1'b0, 8'd255, 8'd255);
    build_frame(4'd15, 1'b0, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3); send_frame();
    build_frame(4'd15, 1'b0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 2); send_frame();
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) begin
        // no idling at all in the final phase
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (IDLE_MAX + 2) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: tx_idle_pct = 0;
          1: tx_idle_pct = 3;
          2: tx_idle_pct = 10;
          default: tx_idle_pct = 25;
        endcase
        case ($urandom_range(0, 3))
          0: rx_stall_pct = 0;
          1: rx_stall_pct = 3;
          2: rx_stall_pct = 10;
          default: rx_stall_pct = 25;
        endcase
      end
      case (ph)
        0: write_cfg(4'd0, 1'b1, 8'd0, 8'd0);
        1: write_cfg(4'd15, 1'b0, 8'd255, 8'd1);
        2: write_cfg(4'd1, 1'b1, 8'd0, 8'd2);
        default: begin
          pick = $urandom_range(0, 255);
          write_cfg(4'($urandom), 1'($urandom), 8'(pick),
                    ($urandom_range(0, 3) == 0) ? 8'(pick) : 8'($urandom));
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RANDOM_BYTES / RAND_PHASES) gen_frame();
      drain();
    end

    repeat (SETTLE * 2) @(posedge clk);
    $display("covered %0d bytes in %0d frames: %0d payload words and %0d summaries checked",
             bytes_sent, frames_sent, sb.payload_words, sb.summaries);
    $display("summary status counts 0..6: %0d %0d %0d %0d %0d %0d %0d", sb.status_seen[0],
             sb.status_seen[1], sb.status_seen[2], sb.status_seen[3], sb.status_seen[4],
             sb.status_seen[5], sb.status_seen[6]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ecpri_header_parser_core: match");
    end else begin
      $display("ecpri_header_parser_core: mismatch");
    end
    $finish;
  end

endmodule

// File: ecpri_header_parser_core.f
rtl/ehp_pkg.sv
rtl/ehp_parse.sv
rtl/ehp_fifo.sv
rtl/ecpri_header_parser_core.sv
rtl/ehp_checker.sv
tb/tb_top.sv
